FILE: rtl/core/skl_pkg.sv
// Shared constants, codes and types for the sorted key leaf insert unit.
package skl_pkg;

    localparam int CAPACITY  = 63;
    localparam int NUM_CELLS = CAPACITY - 1;
    localparam int SPLIT_AT  = NUM_CELLS / 2;
    localparam int SPLIT_RUN = NUM_CELLS - SPLIT_AT;
    localparam int CNT_W     = $clog2(NUM_CELLS + 1);
    localparam int RUN_W     = (SPLIT_RUN > 1) ? $clog2(SPLIT_RUN) : 1;
    localparam int KEY_W     = 64;
    localparam int KEPT_W    = 7;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] STATUS_DUP    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SPLIT  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SPLIT
    } skl_state_t;

    typedef struct packed {
        logic compare;
        logic insert;
        logic shift;
    } skl_cell_ctrl_t;

endpackage

FILE: rtl/core/skl_cell.sv
// One slot of the sorted key chain: compare, ordered insert and split shift.
module skl_cell
    import skl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  skl_cell_ctrl_t   ctrl,
    input  logic             cell_valid,
    input  logic [KEY_W-1:0] bus_key,
    input  logic [KEY_W-1:0] prev_key,
    input  logic             prev_lt,
    input  logic [KEY_W-1:0] next_key,
    output logic [KEY_W-1:0] key,
    output logic             lt,
    output logic             eq
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             lt_reg;
    logic             lt_next;
    logic             eq_reg;
    logic             eq_next;

    always_comb
    begin
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        key_next = key_reg;
        if (ctrl.compare)
        begin
            lt_next = cell_valid && (key_reg < bus_key);
            eq_next = cell_valid && (key_reg == bus_key);
        end
        if (ctrl.insert && !lt_reg)
        begin
            // keep smaller keys, take the new key at the boundary, else move up
            key_next = prev_lt ? bus_key : prev_key;
        end
        else if (ctrl.shift)
        begin
            key_next = next_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

FILE: rtl/core/sorted_unique_key_leaf_insert_unit.sv
// Top level of the sorted unique key leaf insert unit.
//
// Keeps one leaf of up to CAPACITY-2 ascending unique 64-bit keys in a row of
// NUM_CELLS compare cells. An item is taken when start is high and busy low.
// In the accepting cycle every cell compares its key with new_key in parallel;
// in the next cycle a duplicate is reported, or the key drops into place as
// the cells above it move up one slot. A result then shows on the result
// ports for one cycle with valid high, in the first cycle with busy low again.
// When the insert brings the leaf to CAPACITY-1 keys the leaf splits: the upper
// SPLIT_RUN keys move down the cell row one slot a cycle and leave through
// cell SPLIT_AT, one status 2 result a cycle, the split key first. The
// receiver cannot stall: every result must be taken in the cycle it is shown.
// No clearing pass is needed after reset; cells above the fill count are
// never looked at.
module sorted_unique_key_leaf_insert_unit
    import skl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KEY_W-1:0]    new_key,
    output logic                valid,
    output logic [STATUS_W-1:0] status,
    output logic [KEY_W-1:0]    out_key,
    output logic [KEPT_W-1:0]   kept_count,
    output logic                last
);

    skl_state_t          state_reg;
    skl_state_t          state_next;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    key_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [RUN_W-1:0]    run_reg;
    logic [RUN_W-1:0]    run_next;

    logic                valid_reg;
    logic                valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [KEY_W-1:0]    out_key_reg;
    logic [KEY_W-1:0]    out_key_next;
    logic [CNT_W-1:0]    kept_reg;
    logic [CNT_W-1:0]    kept_next;
    logic                last_reg;
    logic                last_next;

    logic                accept;
    logic                dup;
    logic                cmp_en;
    logic                ins_en;
    logic                shift_en;
    logic [KEY_W-1:0]    bus_key;

    logic [KEY_W-1:0]    cell_key [NUM_CELLS];
    logic [NUM_CELLS-1:0] cell_lt;
    logic [NUM_CELLS-1:0] cell_eq;

    assign accept  = start && (state_reg == ST_IDLE);
    assign dup     = |cell_eq;
    // compare against the port on the accepting cycle, the held item after
    assign bus_key = (state_reg == ST_IDLE) ? new_key : key_reg;

    // Cell row: each cell sees its lower and upper neighbour.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        skl_cell_ctrl_t   ctrl;
        logic [KEY_W-1:0] prev_key;
        logic             prev_lt;
        logic [KEY_W-1:0] next_key;

        assign ctrl.compare = cmp_en;
        assign ctrl.insert  = ins_en;
        assign ctrl.shift   = shift_en && (i >= SPLIT_AT);

        if (i == 0)
        begin : g_first
            assign prev_key = '0;
            assign prev_lt  = 1'b1;
        end
        else
        begin : g_inner
            assign prev_key = cell_key[i-1];
            assign prev_lt  = cell_lt[i-1];
        end

        if (i == NUM_CELLS - 1)
        begin : g_top
            assign next_key = '0;
        end
        else
        begin : g_below
            assign next_key = cell_key[i+1];
        end

        skl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .cell_valid (CNT_W'(i) < count_reg),
            .bus_key    (bus_key),
            .prev_key   (prev_key),
            .prev_lt    (prev_lt),
            .next_key   (next_key),
            .key        (cell_key[i]),
            .lt         (cell_lt[i]),
            .eq         (cell_eq[i])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (!dup && (count_reg == CNT_W'(NUM_CELLS - 1)))
                begin
                    state_next = ST_SPLIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SPLIT:
            begin
                if (run_reg == RUN_W'(SPLIT_RUN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs, cell control and datapath registers
    always_comb
    begin
        cmp_en       = 1'b0;
        ins_en       = 1'b0;
        shift_en     = 1'b0;
        key_next     = key_reg;
        count_next   = count_reg;
        run_next     = run_reg;
        valid_next   = 1'b0;
        status_next  = status_reg;
        out_key_next = out_key_reg;
        kept_next    = kept_reg;
        last_next    = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmp_en   = 1'b1;
                    key_next = new_key;
                end
                run_next = '0;
            end
            ST_INSERT:
            begin
                if (dup)
                begin
                    valid_next   = 1'b1;
                    status_next  = STATUS_DUP;
                    out_key_next = key_reg;
                    kept_next    = count_reg;
                    last_next    = 1'b1;
                end
                else if (count_reg == CNT_W'(NUM_CELLS - 1))
                begin
                    // leaf full after this insert: hold results for the split run
                    ins_en     = 1'b1;
                    count_next = CNT_W'(SPLIT_AT);
                end
                else
                begin
                    ins_en       = 1'b1;
                    count_next   = count_reg + 1'b1;
                    valid_next   = 1'b1;
                    status_next  = STATUS_INSERT;
                    out_key_next = key_reg;
                    kept_next    = count_reg + 1'b1;
                    last_next    = 1'b1;
                end
            end
            ST_SPLIT:
            begin
                // drop cell SPLIT_AT out of the leaf and advance the upper cells
                shift_en     = 1'b1;
                valid_next   = 1'b1;
                status_next  = STATUS_SPLIT;
                out_key_next = cell_key[SPLIT_AT];
                kept_next    = CNT_W'(SPLIT_AT);
                last_next    = (run_reg == RUN_W'(SPLIT_RUN - 1));
                run_next     = run_reg + 1'b1;
            end
            default:
            begin
                run_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            run_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            run_reg   <= run_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        status_reg  <= status_next;
        out_key_reg <= out_key_next;
        kept_reg    <= kept_next;
        last_reg    <= last_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign valid      = valid_reg;
    assign status     = status_reg;
    assign out_key    = out_key_reg;
    assign kept_count = KEPT_W'(kept_reg);
    assign last       = last_reg;

endmodule

FILE: rtl/core/skl_checker.sv
// Port level checks for the sorted key leaf insert unit, bound to the top level.
module skl_checker
    import skl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                valid,
    input  logic [STATUS_W-1:0] status,
    input  logic [KEPT_W-1:0]   kept_count,
    input  logic                last
);

    // an accepted item always occupies the unit for the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("unit not busy after accepting an item");

    // duplicate and plain insert results stand alone
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (status == STATUS_DUP || status == STATUS_INSERT) |-> last)
        else $error("single result without last");

    // the final result of an item is never followed straight by another
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |=> !valid)
        else $error("result directly after last");

    // split results always report the lower half left behind
    a_split_kept: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == STATUS_SPLIT |-> kept_count == KEPT_W'(SPLIT_AT))
        else $error("split result with wrong kept count");

    // no status code outside the three defined
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (status == STATUS_DUP || status == STATUS_INSERT ||
                   status == STATUS_SPLIT))
        else $error("undefined status code");

endmodule

bind sorted_unique_key_leaf_insert_unit skl_checker u_skl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .valid      (valid),
    .status     (status),
    .kept_count (kept_count),
    .last       (last)
);

FILE: tb/sv/tb_sorted_unique_key_leaf_insert_unit.sv
// Self-checking testbench for the sorted unique key leaf insert unit.
`timescale 1ns / 100ps

module tb_sorted_unique_key_leaf_insert_unit;
    import skl_pkg::*;

    // One result as it should appear on the result ports.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [KEPT_W-1:0]   kept;
        logic                last;
    } leaf_result_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = SPLIT_RUN + 16;
    localparam int MAX_GAP     = 17;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [KEY_W-1:0]    new_key = '0;
    logic                busy;
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_key;
    logic [KEPT_W-1:0]   kept_count;
    logic                last;

    // Keys still to be offered, the leaf as it should stand, and the results
    // still owed by the block, oldest first.
    logic [KEY_W-1:0] pending_keys[$];
    logic [KEY_W-1:0] leaf_keys[$];
    leaf_result_t     owed_results[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int items_taken = 0;
    int gap_left = 0;

    sorted_unique_key_leaf_insert_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .new_key    (new_key),
        .valid      (valid),
        .status     (status),
        .out_key    (out_key),
        .kept_count (kept_count),
        .last       (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Work out what one accepted key does to the leaf and which results it
    // owes. The leaf is kept sorted; look for the first key not below the
    // new one, report a duplicate there, otherwise drop the key into place.
    task automatic predict_leaf_insert(input logic [KEY_W-1:0] key);
        int pos;
        int fill;
        int split_at;
        leaf_result_t res;
        begin
            pos = 0;
            fill = leaf_keys.size();
            while (pos < fill && leaf_keys[pos] < key)
                pos++;
            res.key = key;
            res.last = 1'b1;
            if (pos < fill && leaf_keys[pos] == key)
            begin
                res.status = STATUS_DUP;
                res.kept = KEPT_W'(fill);
                owed_results.push_back(res);
            end
            else
            begin
                leaf_keys.insert(pos, key);
                fill = fill + 1;
                if (fill + 1 < CAPACITY)
                begin
                    res.status = STATUS_INSERT;
                    res.kept = KEPT_W'(fill);
                    owed_results.push_back(res);
                end
                else
                begin
                    // Leaf full: the upper half leaves in ascending order,
                    // split key first, every result carrying the kept count.
                    split_at = fill / 2;
                    for (int i = split_at; i < fill; i++)
                    begin
                        res.status = STATUS_SPLIT;
                        res.key = leaf_keys[i];
                        res.kept = KEPT_W'(split_at);
                        res.last = (i == fill - 1);
                        owed_results.push_back(res);
                    end
                    while (leaf_keys.size() > split_at)
                        void'(leaf_keys.pop_back());
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [KEY_W-1:0] exp_val,
                               input logic [KEY_W-1:0] act_val);
        begin
            if (exp_val !== act_val)
            begin
                $error("%s: expected %0h, got %0h", name, exp_val, act_val);
                mismatch_count++;
            end
        end
    endtask

    // Driver. Inputs change only at the rising edge through nonblocking
    // assignments; start is decided once per edge so it never toggles within
    // one time step. Hold the item while busy, then idle for a drawn gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            new_key <= '0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_leaf_insert(new_key);
                void'(pending_keys.pop_front());
                items_taken++;
                // Every third stretch of 30 items runs back to back.
                if ((items_taken / 30) % 3 == 2)
                    gap_left = 0;
                else
                    gap_left = $urandom_range(0, MAX_GAP);
            end
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (pending_keys.size() > 0)
            begin
                start <= 1'b1;
                new_key <= pending_keys[0];
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor. Every strobed result is taken at the edge that ends its cycle
    // and matched against the oldest owed result.
    always @(posedge clk)
    begin
        leaf_result_t exp_res;
        if (rst_n && valid)
        begin
            if (owed_results.size() == 0)
            begin
                $error("unexpected result: status %0d key %0h", status, out_key);
                mismatch_count++;
            end
            else
            begin
                exp_res = owed_results.pop_front();
                check_field("status", KEY_W'(exp_res.status), KEY_W'(status));
                check_field("out_key", exp_res.key, out_key);
                check_field("kept_count", KEY_W'(exp_res.kept), KEY_W'(kept_count));
                check_field("last", KEY_W'(exp_res.last), KEY_W'(last));
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus. Keys come in runs: ascending, descending, scattered, and
    // runs heavy with repeats of recent keys, so the leaf fills and splits
    // several times with inserts landing at the front, middle and back.
    initial
    begin
        logic [KEY_W-1:0] sent_keys[$];
        logic [KEY_W-1:0] run_base;
        logic [KEY_W-1:0] stride;
        logic [KEY_W-1:0] key;
        int run_kind;
        int pick;
        int look_back;

        // Extremes, walking patterns and repeats of some of them.
        pending_keys.push_back('0);
        pending_keys.push_back('1);
        pending_keys.push_back('0);
        pending_keys.push_back('1);
        pending_keys.push_back(64'h1);
        pending_keys.push_back(64'hFFFF_FFFF_FFFF_FFFE);
        pending_keys.push_back(64'h8000_0000_0000_0000);
        pending_keys.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        pending_keys.push_back(64'h5555_5555_5555_5555);
        pending_keys.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        pending_keys.push_back(64'h8000_0000_0000_0000);
        pending_keys.push_back(64'h0000_0000_FFFF_FFFF);
        pending_keys.push_back(64'hFFFF_FFFF_0000_0000);
        pending_keys.push_back(64'h1);
        pending_keys.push_back(64'h2);
        foreach (pending_keys[i])
            sent_keys.push_back(pending_keys[i]);

        for (int run = 0; run < 20; run++)
        begin
            run_kind = $urandom_range(0, 3);
            run_base = {$urandom, $urandom};
            stride = KEY_W'($urandom_range(1, 1000));
            for (int j = 0; j < 10; j++)
            begin
                pick = $urandom_range(0, 99);
                case (run_kind)
                    0: key = run_base + stride * j;
                    1: key = run_base - stride * j;
                    default:
                    begin
                        if (pick < 15)
                            key = KEY_W'($urandom_range(0, 255));
                        else if (pick < 25)
                            key = {32'hFFFF_FFFF, $urandom};
                        else
                            key = {$urandom, $urandom};
                    end
                endcase
                // Repeat a recent key now and then, far more often in
                // repeat-heavy runs.
                if (pick < ((run_kind == 3) ? 50 : 10))
                begin
                    look_back = (sent_keys.size() < 40) ? sent_keys.size() : 40;
                    key = sent_keys[sent_keys.size() - 1 - $urandom_range(0, look_back - 1)];
                end
                pending_keys.push_back(key);
                sent_keys.push_back(key);
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_keys.size() != 0 || owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && owed_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
